### src/zmku_pkg.sv
// ----------------------------------------------------------------------------
// zmku_pkg
// Shared types, constants and helpers for the move key update unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package zmku_pkg;

  // board and table geometry
  localparam int unsigned Squares   = 64;
  localparam int unsigned SqW       = $clog2(Squares);
  localparam int unsigned PieceW    = 3;
  localparam int unsigned AddrW     = 1 + PieceW + SqW;
  localparam int unsigned TabDepth  = 1 << AddrW;
  localparam int unsigned KeyW      = 64;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [KeyW-1:0]  key_t;
  typedef logic [SqW-1:0]   sq_t;

  // operation codes
  localparam logic [1:0] OpWrite = 2'd0;
  localparam logic [1:0] OpLoad  = 2'd1;
  localparam logic [1:0] OpMove  = 2'd2;

  // move kinds
  localparam logic [3:0] KindQuiet     = 4'd0;
  localparam logic [3:0] KindCapture   = 4'd1;
  localparam logic [3:0] KindLongCast  = 4'd2;
  localparam logic [3:0] KindShortCast = 4'd3;
  localparam logic [3:0] KindEnPassant = 4'd4;
  localparam logic [3:0] KindPromoLo   = 4'd5;
  localparam logic [3:0] KindPromoHi   = 4'd8;
  localparam logic [3:0] KindCapPrLo   = 4'd9;
  localparam logic [3:0] KindCapPrHi   = 4'd12;

  localparam logic [PieceW-1:0] RookCode = 3'd4;

  // fixed keys
  localparam key_t SideKey = 64'h7C0228DD624EC390;
  localparam key_t CkWk    = 64'hB3598055CE64A656;
  localparam key_t CkWq    = 64'h12A8F886AF9418C2;
  localparam key_t CkBk    = 64'h1877B67E57A764D5;
  localparam key_t CkBq    = 64'hD4490AD346F14431;
  localparam key_t EpOn    = 64'hA3853B80F17F58EE;
  localparam key_t EpX     = 64'h5B23E522E4B1B4EF;
  localparam key_t EpY     = 64'h934E1DE72D36D310;

  // table address from side, piece and square
  function automatic addr_t make_addr(logic s, logic [PieceW-1:0] p, sq_t sq);
    return {s, p, sq};
  endfunction

  // en passant mark contribution
  function automatic key_t ep_term(logic [6:0] ep);
    key_t t;
    t = '0;
    if (ep[6]) begin
      t = EpOn ^ (EpX ^ {{(KeyW-3){1'b0}}, ep[2:0]})
               ^ (EpY ^ {{(KeyW-3){1'b0}}, ep[5:3]});
    end
    return t;
  endfunction

  // castling rights that changed
  function automatic key_t castle_term(logic [3:0] c_old, logic [3:0] c_new);
    logic [3:0] chg;
    key_t       t;
    chg = c_old ^ c_new;
    t   = '0;
    if (chg[0]) t = t ^ CkWk;
    if (chg[1]) t = t ^ CkWq;
    if (chg[2]) t = t ^ CkBk;
    if (chg[3]) t = t ^ CkBq;
    return t;
  endfunction

  // number of table reads a move needs
  function automatic logic [2:0] read_count(logic [3:0] kind);
    logic [2:0] n;
    if (kind == KindQuiet) n = 3'd2;
    else if (kind == KindCapture || kind == KindEnPassant) n = 3'd3;
    else if (kind == KindLongCast || kind == KindShortCast) n = 3'd4;
    else if (kind >= KindPromoLo && kind <= KindPromoHi) n = 3'd2;
    else if (kind >= KindCapPrLo && kind <= KindCapPrHi) n = 3'd3;
    else n = 3'd0;
    return n;
  endfunction

endpackage

### src/zobrist_move_key_update_unit.sv
// ----------------------------------------------------------------------------
// zobrist_move_key_update_unit
// Incremental position key: table of piece keys plus a running key that a
// move updates by XOR, one table read per cycle.
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// command   in         start high, busy low      op_i .. data_i
// result    out        done_o one-cycle strobe   key_o
//
// table write, key load, unused op and a move that changes no piece: result
// strobe in the cycle after accept, busy stays low. other moves: n = 2..4
// table reads through the single read port of the key table in ST_RUN, then
// ST_FLUSH folds in the last read and strobes the result.
// reset clears the running key and the sequencer; the key table is not
// cleared. the receiver cannot stall, the result is shown for one cycle.
`timescale 1ns / 1ps

module zobrist_move_key_update_unit
  import zmku_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        op_i,
  input  logic              side_i,
  input  logic [2:0]        piece_i,
  input  logic [5:0]        from_sq_i,
  input  logic [5:0]        to_sq_i,
  input  logic [3:0]        move_kind_i,
  input  logic [2:0]        captured_piece_i,
  input  logic [3:0]        castle_old_i,
  input  logic [3:0]        castle_new_i,
  input  logic [6:0]        ep_old_i,
  input  logic [6:0]        ep_new_i,
  input  logic [63:0]       data_i,
  output logic              done_o,
  output logic [63:0]       key_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_e;

  state_e       state_q;
  logic         done_q;
  key_t         run_key_q;
  key_t         acc_q;
  logic [1:0]   idx_q;
  logic [2:0]   n_q;
  logic         pend_q;

  // latched move fields
  logic         side_q;
  logic [2:0]   piece_q;
  sq_t          from_q;
  sq_t          to_q;
  logic [3:0]   kind_q;
  logic [2:0]   cap_q;

  // key table
  key_t         mem_q [TabDepth];
  key_t         rdata_q;
  addr_t        raddr;
  logic         accept;
  logic         mem_we;
  logic         last_issue;
  key_t         fixed_term;
  logic [2:0]   n_in;

  assign accept = start && (state_q == ST_IDLE);
  assign mem_we = accept && (op_i == OpWrite);
  assign n_in   = read_count(move_kind_i);

  // side, castling and en passant toggles of the incoming move
  assign fixed_term = SideKey ^ castle_term(castle_old_i, castle_new_i)
                    ^ ep_term(ep_old_i) ^ ep_term(ep_new_i);

  assign last_issue = ({1'b0, idx_q} + 3'd1) == n_q;

  // read address for the current step
  always_comb begin
    logic         opp;
    logic [2:0]   pr;
    sq_t          victim;
    opp    = ~side_q;
    pr     = 3'(kind_q - 4'd3);
    victim = side_q ? sq_t'(to_q - 6'd8) : sq_t'(to_q + 6'd8);
    raddr  = make_addr(side_q, piece_q, from_q);
    unique case (idx_q)
      2'd0: raddr = make_addr(side_q, piece_q, from_q);
      2'd1: begin
        if (kind_q <= KindEnPassant) begin
          raddr = make_addr(side_q, piece_q, to_q);
        end else if (kind_q <= KindPromoHi) begin
          raddr = make_addr(side_q, pr, to_q);
        end else begin
          raddr = make_addr(side_q, 3'(kind_q - 4'd7), to_q);
        end
      end
      2'd2: begin
        priority if (kind_q == KindLongCast) begin
          raddr = make_addr(side_q, RookCode, side_q ? 6'd0 : 6'd56);
        end else if (kind_q == KindShortCast) begin
          raddr = make_addr(side_q, RookCode, side_q ? 6'd7 : 6'd63);
        end else if (kind_q == KindEnPassant) begin
          raddr = make_addr(opp, cap_q, victim);
        end else begin
          raddr = make_addr(opp, cap_q, to_q);
        end
      end
      2'd3: begin
        if (kind_q == KindLongCast) begin
          raddr = make_addr(side_q, RookCode, side_q ? 6'd3 : 6'd59);
        end else begin
          raddr = make_addr(side_q, RookCode, side_q ? 6'd5 : 6'd61);
        end
      end
      default: raddr = make_addr(side_q, piece_q, from_q);
    endcase
  end

  // table port: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[make_addr(side_i, piece_i, to_sq_i)] <= data_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // latch the move on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      side_q  <= side_i;
      piece_q <= piece_i;
      from_q  <= from_sq_i;
      to_q    <= to_sq_i;
      kind_q  <= move_kind_i;
      cap_q   <= captured_piece_i;
      n_q     <= n_in;
    end
  end

  // sequencer, accumulator and running key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      run_key_q <= '0;
      acc_q     <= '0;
      idx_q     <= '0;
      pend_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      pend_q <= (state_q == ST_RUN);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q <= '0;
            if (op_i == OpLoad) begin
              run_key_q <= data_i;
              done_q    <= 1'b1;
            end else if (op_i == OpMove) begin
              if (n_in == 3'd0) begin
                run_key_q <= run_key_q ^ fixed_term;
                done_q    <= 1'b1;
              end else begin
                acc_q   <= run_key_q ^ fixed_term;
                state_q <= ST_RUN;
              end
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        ST_RUN: begin
          if (pend_q) begin
            acc_q <= acc_q ^ rdata_q;
          end
          idx_q <= idx_q + 2'd1;
          if (last_issue) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          run_key_q <= acc_q ^ rdata_q;
          done_q    <= 1'b1;
          state_q   <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign key_o  = run_key_q;

endmodule

### src/zmku_checker.sv
// ----------------------------------------------------------------------------
// zmku_checker
// Port-level checks of the move key update unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zmku_checker
  import zmku_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  op_i,
  input logic [63:0] data_i,
  input logic        done_o,
  input logic [63:0] key_o
);

  // a result word only appears once the unit is free again
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // non-move commands answer in the next cycle
  a_short_ops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i != OpMove) |=> (done_o && !busy))
    else $error("short command did not answer next cycle");

  // an accepted word either finishes or keeps the unit busy
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted word lost");

  // the end of a move always delivers a result word
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy ended without a result");

  // a key load returns the loaded value
  a_load_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OpLoad) |=> (key_o == $past(data_i)))
    else $error("loaded key mismatch");

endmodule

bind zobrist_move_key_update_unit zmku_checker u_zmku_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .op_i   (op_i),
  .data_i (data_i),
  .done_o (done_o),
  .key_o  (key_o)
);

### test/tb_zobrist_move_key_update_unit.sv
// ----------------------------------------------------------------------------
// tb_zobrist_move_key_update_unit
// Self-checking bench for the move key update unit. Table writes, key loads,
// unused ops and moves of every kind go in through the start/busy port. A
// bench-side position model predicts each key, and every done_o strobe is
// compared in order. The sender runs in random bursts and sometimes holds
// off until all keys are back. Moves only read table entries written before.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_zobrist_move_key_update_unit;
  import zmku_pkg::*;

  // codes with no name in the package
  localparam logic [1:0] OpNone      = 2'd3;
  localparam logic [3:0] KindTop     = 4'd15;
  localparam logic [2:0] PieceKnight = 3'd2;
  localparam logic [2:0] PieceKing   = 3'd6;

  // fixed keys of the scheme
  localparam key_t SideToMoveKey = 64'h7C0228DD624EC390;
  localparam key_t WhiteShortKey = 64'hB3598055CE64A656;
  localparam key_t WhiteLongKey  = 64'h12A8F886AF9418C2;
  localparam key_t BlackShortKey = 64'h1877B67E57A764D5;
  localparam key_t BlackLongKey  = 64'hD4490AD346F14431;
  localparam key_t EpValidKey    = 64'hA3853B80F17F58EE;
  localparam key_t EpFileKey     = 64'h5B23E522E4B1B4EF;
  localparam key_t EpRankKey     = 64'h934E1DE72D36D310;

  localparam int IdleLimit  = 200;
  localparam int TotalWords = 1650;

  typedef struct packed {
    logic       pause_before;
    logic [1:0] op;
    logic       side;
    logic [2:0] piece;
    sq_t        from_sq;
    sq_t        to_sq;
    logic [3:0] kind;
    logic [2:0] cap;
    logic [3:0] castle_old;
    logic [3:0] castle_new;
    logic [6:0] ep_old;
    logic [6:0] ep_new;
    key_t       data;
  } word_t;

  typedef struct packed {
    logic [2:0]      n;
    addr_t [3:0]     a;
  } reads_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op_i = '0;
  logic        side_i = 1'b0;
  logic [2:0]  piece_i = '0;
  logic [5:0]  from_sq_i = '0;
  logic [5:0]  to_sq_i = '0;
  logic [3:0]  move_kind_i = '0;
  logic [2:0]  captured_piece_i = '0;
  logic [3:0]  castle_old_i = '0;
  logic [3:0]  castle_new_i = '0;
  logic [6:0]  ep_old_i = '0;
  logic [6:0]  ep_new_i = '0;
  logic [63:0] data_i = '0;
  logic        done_o;
  logic [63:0] key_o;

  zobrist_move_key_update_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .side_i           (side_i),
    .piece_i          (piece_i),
    .from_sq_i        (from_sq_i),
    .to_sq_i          (to_sq_i),
    .move_kind_i      (move_kind_i),
    .captured_piece_i (captured_piece_i),
    .castle_old_i     (castle_old_i),
    .castle_new_i     (castle_new_i),
    .ep_old_i         (ep_old_i),
    .ep_new_i         (ep_new_i),
    .data_i           (data_i),
    .done_o           (done_o),
    .key_o            (key_o)
  );

  // bench state
  word_t queued_words[$];
  key_t  awaited_keys[$];
  bit    entry_loaded [TabDepth];
  key_t  piece_keys [TabDepth];
  key_t  position_key = '0;
  word_t cur;
  int    n_issued = 0;
  int    n_done = 0;
  int    errors = 0;
  int    burst_left = 1;
  int    gap_left = 0;
  int    idle_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // table entries a move reads, with multiplicity
  function automatic reads_t table_reads(word_t w);
    reads_t     r;
    logic       opp;
    logic [3:0] ofs;
    sq_t        victim;
    r   = '0;
    opp = ~w.side;
    ofs = '0;
    if (w.op == OpMove) begin
      if (w.kind <= KindEnPassant) begin
        r.a[0] = {w.side, w.piece, w.from_sq};
        r.a[1] = {w.side, w.piece, w.to_sq};
        r.n    = 3'd2;
        case (w.kind)
          KindCapture: begin
            r.a[2] = {opp, w.cap, w.to_sq};
            r.n    = 3'd3;
          end
          // rook corner and landing square of the moving side
          KindLongCast: begin
            r.a[2] = {w.side, RookCode, w.side ? 6'd0 : 6'd56};
            r.a[3] = {w.side, RookCode, w.side ? 6'd3 : 6'd59};
            r.n    = 3'd4;
          end
          KindShortCast: begin
            r.a[2] = {w.side, RookCode, w.side ? 6'd7 : 6'd63};
            r.a[3] = {w.side, RookCode, w.side ? 6'd5 : 6'd61};
            r.n    = 3'd4;
          end
          // victim sits one rank behind the target, wrapping on the board
          KindEnPassant: begin
            victim = w.side ? w.to_sq - 6'd8 : w.to_sq + 6'd8;
            r.a[2] = {opp, w.cap, victim};
            r.n    = 3'd3;
          end
          default: ;
        endcase
      end else if (w.kind <= KindPromoHi) begin
        ofs    = w.kind - KindPromoLo;
        r.a[0] = {w.side, w.piece, w.from_sq};
        r.a[1] = {w.side, PieceKnight + ofs[2:0], w.to_sq};
        r.n    = 3'd2;
      end else if (w.kind <= KindCapPrHi) begin
        ofs    = w.kind - KindCapPrLo;
        r.a[0] = {w.side, w.piece, w.from_sq};
        r.a[1] = {w.side, PieceKnight + ofs[2:0], w.to_sq};
        r.a[2] = {opp, w.cap, w.to_sq};
        r.n    = 3'd3;
      end
    end
    return r;
  endfunction

  // en passant mark toggle
  function automatic key_t ep_mark(logic [6:0] ep);
    key_t t;
    t = '0;
    if (ep[6]) t = EpValidKey ^ (EpFileKey ^ {61'd0, ep[2:0]}) ^ (EpRankKey ^ {61'd0, ep[5:3]});
    return t;
  endfunction

  // position model: applies one accepted word, returns the new key
  task automatic advance_position(input word_t w, output key_t k);
    reads_t     r;
    logic [3:0] chg;
    r = table_reads(w);
    case (w.op)
      OpWrite: piece_keys[{w.side, w.piece, w.to_sq}] = w.data;
      OpLoad:  position_key = w.data;
      OpMove: begin
        for (int i = 0; i < r.n; i++) position_key ^= piece_keys[r.a[i]];
        position_key ^= SideToMoveKey;
        chg = w.castle_old ^ w.castle_new;
        if (chg[0]) position_key ^= WhiteShortKey;
        if (chg[1]) position_key ^= WhiteLongKey;
        if (chg[2]) position_key ^= BlackShortKey;
        if (chg[3]) position_key ^= BlackLongKey;
        position_key ^= ep_mark(w.ep_old) ^ ep_mark(w.ep_new);
      end
      default: ;
    endcase
    k = position_key;
  endtask

  function automatic word_t random_word();
    word_t w;
    w.pause_before = 1'b0;
    w.op           = 2'($urandom_range(0, 3));
    w.side         = 1'($urandom_range(0, 1));
    w.piece        = 3'($urandom_range(0, 7));
    w.from_sq      = 6'($urandom_range(0, 63));
    w.to_sq        = 6'($urandom_range(0, 63));
    w.kind         = 4'($urandom_range(0, 15));
    w.cap          = 3'($urandom_range(0, 7));
    w.castle_old   = 4'($urandom_range(0, 15));
    w.castle_new   = 4'($urandom_range(0, 15));
    w.ep_old       = 7'($urandom_range(0, 127));
    w.ep_new       = 7'($urandom_range(0, 127));
    w.data         = {$urandom, $urandom};
    return w;
  endfunction

  // mostly legal piece codes, now and then the unused ones
  function automatic word_t random_move();
    word_t w;
    w    = random_word();
    w.op = OpMove;
    if ($urandom_range(0, 9) != 0) w.piece = 3'($urandom_range(1, 6));
    if ($urandom_range(0, 9) != 0) w.cap = 3'($urandom_range(1, 6));
    if ($urandom_range(0, 3) == 0) w.castle_new = w.castle_old;
    if ($urandom_range(0, 19) == 0) w.from_sq = w.to_sq;
    return w;
  endfunction

  // queue a word, first writing any table entry it reads that was never set
  task automatic enqueue(input word_t w);
    reads_t r;
    word_t  fill;
    r = table_reads(w);
    for (int i = 0; i < r.n; i++) begin
      if (!entry_loaded[r.a[i]]) begin
        fill    = random_word();
        fill.op = OpWrite;
        {fill.side, fill.piece, fill.to_sq} = r.a[i];
        entry_loaded[r.a[i]] = 1'b1;
        queued_words.push_back(fill);
      end
    end
    if (w.op == OpWrite) entry_loaded[{w.side, w.piece, w.to_sq}] = 1'b1;
    queued_words.push_back(w);
  endtask

  // driver: presents words in bursts, predicts each accepted one
  always @(posedge clk_i) begin
    key_t k;
    logic go;
    if (rst_ni) begin
      if (start && !busy) begin
        advance_position(cur, k);
        awaited_keys.push_back(k);
        n_issued++;
      end
      if (!(start && busy)) begin
        go = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (queued_words.size() != 0 &&
                     !(queued_words[0].pause_before && n_done < n_issued)) begin
          cur              = queued_words.pop_front();
          go               = 1'b1;
          op_i             <= cur.op;
          side_i           <= cur.side;
          piece_i          <= cur.piece;
          from_sq_i        <= cur.from_sq;
          to_sq_i          <= cur.to_sq;
          move_kind_i      <= cur.kind;
          captured_piece_i <= cur.cap;
          castle_old_i     <= cur.castle_old;
          castle_new_i     <= cur.castle_new;
          ep_old_i         <= cur.ep_old;
          ep_new_i         <= cur.ep_new;
          data_i           <= cur.data;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
        start <= go;
      end
    end
  end

  // monitor: each done_o strobe against the oldest awaited key
  always @(posedge clk_i) begin
    key_t want;
    if (rst_ni && done_o) begin
      if (awaited_keys.size() == 0) begin
        $display("%0t: unexpected key, expected none, actual %h", $time, key_o);
        errors++;
      end else begin
        want = awaited_keys.pop_front();
        if (key_o !== want) begin
          $display("%0t: key mismatch, expected %h, actual %h", $time, want, key_o);
          errors++;
        end
      end
      n_done <= n_done + 1;
    end
  end

  // watchdog on cycles with no word accepted and no key returned
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles", $time, IdleLimit);
        $display("zobrist_move_key_update_unit: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    word_t w;
    int    pick;

    // key loads and table writes at the extremes, unused op
    w = random_word(); w.op = OpLoad; w.data = '1; enqueue(w);
    w = random_word(); w.op = OpWrite; w.side = 1'b1; w.piece = 3'd7; w.to_sq = 6'd63;
    w.data = '1; enqueue(w);
    w = random_word(); w.op = OpWrite; w.side = 1'b0; w.piece = 3'd0; w.to_sq = 6'd0;
    w.data = '0; enqueue(w);
    w = random_word(); w.op = OpNone; enqueue(w);
    w = random_word(); w.op = OpLoad; w.data = '0; enqueue(w);

    // every move kind, both sides, extreme squares and marks
    for (int k = 0; k <= KindTop; k++) begin
      w            = random_move();
      w.kind       = 4'(k);
      w.side       = k[0];
      w.from_sq    = k[1] ? 6'd63 : 6'd0;
      w.to_sq      = k[1] ? 6'd0 : 6'd63;
      w.castle_old = k[0] ? 4'hF : 4'h0;
      w.castle_new = k[0] ? 4'h0 : 4'hF;
      w.ep_old     = k[1] ? 7'h7F : 7'h00;
      w.ep_new     = k[2] ? 7'h40 : 7'h3F;
      if (w.kind == KindLongCast || w.kind == KindShortCast) w.piece = PieceKing;
      enqueue(w);
    end

    // en passant victim wrapping past either board edge
    w = random_move(); w.kind = KindEnPassant; w.side = 1'b1; w.to_sq = 6'd3; enqueue(w);
    w = random_move(); w.kind = KindEnPassant; w.side = 1'b0; w.to_sq = 6'd60; enqueue(w);

    // random mix, mostly moves; some words wait for all keys to drain
    for (int i = 0; queued_words.size() < TotalWords; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        w = random_word(); w.op = OpWrite;
      end else if (pick < 12) begin
        w = random_word(); w.op = OpLoad;
      end else if (pick < 14) begin
        w = random_word(); w.op = OpNone;
      end else begin
        w = random_move();
      end
      w.pause_before = (i == 0) || ($urandom_range(0, 49) == 0);
      enqueue(w);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (queued_words.size() != 0 || start || n_done < n_issued);
    repeat (10) @(negedge clk_i);

    if (awaited_keys.size() != 0) begin
      $display("%0t: %0d keys never returned, next expected %h, actual none",
               $time, awaited_keys.size(), awaited_keys[0]);
      errors += awaited_keys.size();
    end
    if (errors == 0) begin
      $display("zobrist_move_key_update_unit: match");
    end else begin
      $display("zobrist_move_key_update_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
src/zmku_pkg.sv
src/zobrist_move_key_update_unit.sv
src/zmku_checker.sv
test/tb_zobrist_move_key_update_unit.sv
